[design/fixed_capacity_multiset_table_top_macros.svh]
// Assertion macros shared by the multiset table RTL.
// Included by the files that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef FIXED_CAPACITY_MULTISET_TABLE_TOP_MACROS_SVH
`define FIXED_CAPACITY_MULTISET_TABLE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define FCMT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FCMT_ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define FCMT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define FCMT_ASSERT(lbl, prop, msg)
`define FCMT_ASSERT_IMPL(lbl, pre, post, msg)
`define FCMT_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[design/fcmt_pkg.sv]
// Package for the multiset table: payload structs, action codes, sequencer states.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package fcmt_pkg;

    localparam int FCMT_CAPACITY    = 16;
    localparam int FCMT_VALUE_WIDTH = 32;
    localparam int ITEM_WIDTH       = 32;
    localparam int CNT_OUT_WIDTH    = 5;

    typedef enum logic [2:0] {
        ACT_ADD        = 3'd0,
        ACT_ADD_UNIQUE = 3'd1,
        ACT_REMOVE     = 3'd2,
        ACT_QUERY      = 3'd3,
        ACT_CLEAR      = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic [2:0]            action;
        logic [ITEM_WIDTH-1:0] item_value;
    } req_item_t;

    typedef struct packed {
        logic                     ok;
        logic [CNT_OUT_WIDTH-1:0] match_count;
        logic [CNT_OUT_WIDTH-1:0] fill_level;
    } rsp_item_t;

    // Control from the sequencer to the compare unit.
    typedef struct packed {
        logic clear;
        logic sample;
    } scan_ctl_t;

endpackage

[design/fcmt_store.sv]
// Entry memory of the multiset table: one write port, one read port, registered read data.
// Depends on fcmt_pkg.
`timescale 1ns / 1ps
module fcmt_store
    import fcmt_pkg::*;
#(
    parameter int CAPACITY    = FCMT_CAPACITY,
    parameter int VALUE_WIDTH = FCMT_VALUE_WIDTH,
    localparam int AW         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
)
(
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  logic [VALUE_WIDTH-1:0] wr_data,
    input  logic                   rd_en,
    input  logic [AW-1:0]          rd_addr,
    output logic [VALUE_WIDTH-1:0] rd_data
);

    logic [VALUE_WIDTH-1:0] mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/fcmt_scan.sv]
// Shared compare unit: one equality comparator that tallies matches over a table walk.
// Depends on fcmt_pkg for the control struct.
`timescale 1ns / 1ps
module fcmt_scan
    import fcmt_pkg::*;
#(
    parameter int CAPACITY    = FCMT_CAPACITY,
    parameter int VALUE_WIDTH = FCMT_VALUE_WIDTH,
    localparam int AW         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW         = $clog2(CAPACITY + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  scan_ctl_t              ctl,
    input  logic [AW-1:0]          addr,
    input  logic [VALUE_WIDTH-1:0] data,
    input  logic [VALUE_WIDTH-1:0] key,
    output logic                   found,
    output logic [CW-1:0]          match_tally,
    output logic [AW-1:0]          first,
    output logic [VALUE_WIDTH-1:0] last
);

    logic                   found_reg,   found_next;
    logic [CW-1:0]          matches_reg, matches_next;
    logic [AW-1:0]          first_reg,   first_next;
    logic [VALUE_WIDTH-1:0] last_reg,    last_next;
    logic                   hit;

    assign hit = (data == key);

    always_comb
    begin
        found_next   = found_reg;
        matches_next = matches_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        if (ctl.clear)
        begin
            found_next   = 1'b0;
            matches_next = '0;
        end
        else if (ctl.sample)
        begin
            // The final sample of a walk is the top entry, kept for remove.
            last_next = data;
            if (hit)
            begin
                matches_next = matches_reg + CW'(1);
                if (!found_reg)
                begin
                    found_next = 1'b1;
                    first_next = addr;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg   <= 1'b0;
            matches_reg <= '0;
        end
        else
        begin
            found_reg   <= found_next;
            matches_reg <= matches_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        last_reg  <= last_next;
    end

    assign found       = found_reg;
    assign match_tally = matches_reg;
    assign first       = first_reg;
    assign last        = last_reg;

endmodule

[design/fcmt_seq.sv]
// Sequencer of the multiset table: walks the entries, then applies the action.
// Depends on fcmt_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "fixed_capacity_multiset_table_top_macros.svh"
module fcmt_seq
    import fcmt_pkg::*;
#(
    parameter int CAPACITY    = FCMT_CAPACITY,
    parameter int VALUE_WIDTH = FCMT_VALUE_WIDTH,
    localparam int AW         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW         = $clog2(CAPACITY + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [2:0]             req_action,
    input  logic [VALUE_WIDTH-1:0] key,
    input  logic                   out_busy,
    input  logic                   found,
    input  logic [CW-1:0]          match_tally,
    input  logic [AW-1:0]          first,
    input  logic [VALUE_WIDTH-1:0] last,
    output logic                   ready,
    output scan_ctl_t              scan_ctl,
    output logic [AW-1:0]          sample_addr,
    output logic                   rd_en,
    output logic [AW-1:0]          rd_addr,
    output logic                   wr_en,
    output logic [AW-1:0]          wr_addr,
    output logic [VALUE_WIDTH-1:0] wr_data,
    output rsp_item_t              result,
    output logic                   result_load
);

    state_t        state_reg,  state_next;
    logic [CW-1:0] idx_reg,    idx_next;
    logic          pend_reg,   pend_next;
    logic [AW-1:0] paddr_reg,  paddr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [2:0]    action_reg, action_next;

    logic          room;
    logic          ok;
    logic [CW-1:0] match_after;
    logic [CW+CNT_OUT_WIDTH-1:0] match_wide;
    logic [CW+CNT_OUT_WIDTH-1:0] fill_wide;

    assign room = (count_reg < CW'(CAPACITY));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (req_action == ACT_CLEAR) ? ST_UPDATE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!rd_en && !pend_reg)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath updates.
    always_comb
    begin
        ready       = (state_reg == ST_IDLE);
        rd_en       = (state_reg == ST_SCAN) && (idx_reg < count_reg);
        rd_addr     = idx_reg[AW-1:0];
        scan_ctl.clear  = (state_reg == ST_IDLE) && start;
        scan_ctl.sample = pend_reg;
        sample_addr = paddr_reg;
        result_load = (state_reg == ST_UPDATE) && !out_busy;

        idx_next    = idx_reg;
        pend_next   = 1'b0;
        paddr_next  = paddr_reg;
        action_next = action_reg;
        if (scan_ctl.clear)
        begin
            idx_next    = '0;
            action_next = req_action;
        end
        if (rd_en)
        begin
            idx_next   = idx_reg + CW'(1);
            pend_next  = 1'b1;
            paddr_next = idx_reg[AW-1:0];
        end

        ok          = 1'b0;
        match_after = match_tally;
        count_next  = count_reg;
        wr_en       = 1'b0;
        wr_addr     = count_reg[AW-1:0];
        wr_data     = key;
        unique case (action_reg)
            ACT_ADD:
            begin
                ok = room;
            end
            ACT_ADD_UNIQUE:
            begin
                ok = room && !found;
            end
            ACT_REMOVE:
            begin
                ok      = found;
                wr_addr = first;
                wr_data = last;
            end
            ACT_QUERY:
            begin
                ok = found;
            end
            ACT_CLEAR:
            begin
                ok = 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase

        if (action_reg == ACT_ADD || action_reg == ACT_ADD_UNIQUE)
        begin
            if (ok)
            begin
                match_after = match_tally + CW'(1);
                if (result_load)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
        end
        else if (action_reg == ACT_REMOVE)
        begin
            if (ok)
            begin
                // The top entry moves into the freed slot.
                match_after = match_tally - CW'(1);
                if (result_load)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
        end
        else if (action_reg == ACT_CLEAR)
        begin
            match_after = '0;
            if (result_load)
            begin
                count_next = '0;
            end
        end

        match_wide = {{CNT_OUT_WIDTH{1'b0}}, match_after};
        fill_wide  = {{CNT_OUT_WIDTH{1'b0}}, count_next};
        if (action_reg == ACT_CLEAR)
        begin
            fill_wide = '0;
        end
        result.ok          = ok;
        result.match_count = match_wide[CNT_OUT_WIDTH-1:0];
        result.fill_level  = fill_wide[CNT_OUT_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            pend_reg   <= 1'b0;
            count_reg  <= '0;
            action_reg <= 3'(ACT_QUERY);
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            pend_reg   <= pend_next;
            count_reg  <= count_next;
            action_reg <= action_next;
        end
    end

    always_ff @(posedge clk)
    begin
        paddr_reg <= paddr_next;
    end

    `FCMT_ASSERT(a_count_in_range, count_reg <= CW'(CAPACITY), "entry count above capacity")
    `FCMT_ASSERT_IMPL(a_write_in_update, wr_en, state_reg == ST_UPDATE && result_load,
        "table written outside the update step")
    `FCMT_ASSERT_IMPL(a_read_below_count, rd_en, idx_reg < count_reg,
        "read issued at or above the entry count")
    `FCMT_ASSERT_NEXT(a_count_holds, state_reg != ST_UPDATE, $stable(count_reg),
        "entry count changed outside the update step")

endmodule

[design/fixed_capacity_multiset_table_top.sv]
// Top level of the fixed-capacity multiset table.
// Depends on fcmt_pkg, fcmt_store, fcmt_scan and fcmt_seq.
//
//   channel | signals                 | payload
//   --------+-------------------------+--------------------------------------
//   request | req_valid, req_ready    | req : action, item_value
//   result  | rsp_valid, rsp_ready    | rsp : ok, match_count, fill_level
//
// Each transaction walks the held entries through the single read port and comparator,
// one entry per cycle, and then loads its result in the update step. A clear skips the
// walk and goes straight to the update step. req_ready returns in the cycle after the
// result is loaded. Reset empties the table at once; no clearing pass is run.
// A result waiting on rsp_ready holds the next transaction in its update step; the walk
// itself goes on, so the next request is still taken while a result waits.
`timescale 1ns / 1ps
module fixed_capacity_multiset_table_top
    import fcmt_pkg::*;
#(
    parameter int CAPACITY    = FCMT_CAPACITY,
    parameter int VALUE_WIDTH = FCMT_VALUE_WIDTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic                   start;
    logic [VALUE_WIDTH-1:0] key_in;
    logic [VALUE_WIDTH-1:0] key_reg;
    scan_ctl_t              scan_ctl;
    logic [AW-1:0]          sample_addr;
    logic                   rd_en, wr_en;
    logic [AW-1:0]          rd_addr, wr_addr;
    logic [VALUE_WIDTH-1:0] rd_data, wr_data;
    logic                   found;
    logic [CW-1:0]          match_tally;
    logic [AW-1:0]          first;
    logic [VALUE_WIDTH-1:0] last;
    rsp_item_t              result;
    logic                   result_load;
    logic                   out_busy;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_item_t              rsp_reg;

    assign start    = req_valid && req_ready;
    assign out_busy = rsp_valid_reg && !rsp_ready;

    generate
        if (VALUE_WIDTH <= ITEM_WIDTH)
        begin : g_key_narrow
            assign key_in = req.item_value[VALUE_WIDTH-1:0];
        end
        else
        begin : g_key_wide
            assign key_in = {{(VALUE_WIDTH-ITEM_WIDTH){1'b0}}, req.item_value};
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_reg <= key_in;
        end
    end

    fcmt_store #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fcmt_scan #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (scan_ctl),
        .addr        (sample_addr),
        .data        (rd_data),
        .key         (key_reg),
        .found       (found),
        .match_tally (match_tally),
        .first       (first),
        .last        (last)
    );

    fcmt_seq #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .req_action  (req.action),
        .key         (key_reg),
        .out_busy    (out_busy),
        .found       (found),
        .match_tally (match_tally),
        .first       (first),
        .last        (last),
        .ready       (req_ready),
        .scan_ctl    (scan_ctl),
        .sample_addr (sample_addr),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .result      (result),
        .result_load (result_load)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (result_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[dv/fcmt_result_checker.sv]
// Result checker for the multiset table: watches both channels, predicts each result
// from its own copy of the table and compares it field by field. Depends on fcmt_pkg.
`timescale 1ns / 1ps
module fcmt_result_checker
    import fcmt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_ready,
    input  req_item_t req,
    input  logic      rsp_valid,
    input  logic      rsp_ready,
    input  rsp_item_t rsp,
    output int        error_count,
    output int        outstanding
);

    logic [ITEM_WIDTH-1:0] held_values [FCMT_CAPACITY];
    int                    held_count;
    rsp_item_t             expected_results [$];
    rsp_item_t             oldest;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Applies one action to the shadow table and returns the result it should produce.
    function automatic rsp_item_t apply_action(input logic [2:0] act,
                                               input logic [ITEM_WIDTH-1:0] val);
        int        slot;
        int        hits;
        rsp_item_t res;
        slot = -1;
        for (int i = 0; i < held_count; i++)
        begin
            if (slot < 0 && held_values[i] == val)
            begin
                slot = i;
            end
        end
        res.ok = 1'b0;
        case (act)
            ACT_ADD:
            begin
                if (held_count < FCMT_CAPACITY)
                begin
                    held_values[held_count] = val;
                    held_count++;
                    res.ok = 1'b1;
                end
            end
            ACT_ADD_UNIQUE:
            begin
                if (slot < 0 && held_count < FCMT_CAPACITY)
                begin
                    held_values[held_count] = val;
                    held_count++;
                    res.ok = 1'b1;
                end
            end
            ACT_REMOVE:
            begin
                // The last entry fills the hole left by the first match.
                if (slot >= 0)
                begin
                    held_count--;
                    held_values[slot] = held_values[held_count];
                    res.ok = 1'b1;
                end
            end
            ACT_QUERY:
            begin
                res.ok = (slot >= 0);
            end
            ACT_CLEAR:
            begin
                held_count = 0;
                res.ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        hits = 0;
        for (int i = 0; i < held_count; i++)
        begin
            if (held_values[i] == val)
            begin
                hits++;
            end
        end
        res.match_count = hits[CNT_OUT_WIDTH-1:0];
        res.fill_level  = held_count[CNT_OUT_WIDTH-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count = 0;
            expected_results.delete();
            error_count = 0;
            outstanding = 0;
        end
        else
        begin
            // Results are taken before requests so that a request accepted on the
            // same edge never pairs with an earlier result.
            if (rsp_valid && rsp_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("result with no transaction pending: ok %0d count %0d fill %0d",
                                              rsp.ok, rsp.match_count, rsp.fill_level));
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (rsp.ok !== oldest.ok)
                    begin
                        report_mismatch($sformatf("ok is %0d, expected %0d",
                                                  rsp.ok, oldest.ok));
                    end
                    if (rsp.match_count !== oldest.match_count)
                    begin
                        report_mismatch($sformatf("match_count is %0d, expected %0d",
                                                  rsp.match_count, oldest.match_count));
                    end
                    if (rsp.fill_level !== oldest.fill_level)
                    begin
                        report_mismatch($sformatf("fill_level is %0d, expected %0d",
                                                  rsp.fill_level, oldest.fill_level));
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                expected_results.push_back(apply_action(req.action, req.item_value));
            end
            outstanding = expected_results.size();
        end
    end

endmodule

[dv/tb_fixed_capacity_multiset_table_top.sv]
// Testbench top for the multiset table: clock, reset, request stimulus, result
// back-pressure and the verdict. Depends on fcmt_pkg, the block and fcmt_result_checker.
`timescale 1ns / 1ps
module tb_fixed_capacity_multiset_table_top;
    import fcmt_pkg::*;

    localparam int              GAP_MAX             = 7;
    localparam int              LONG_HOLD           = 400;
    localparam int              IDLE_LIMIT          = 4000;
    localparam int              ROUNDS              = 14;
    localparam int              ROUND_ITEMS         = 104;
    localparam int              POOL_SIZE           = 5;
    localparam int              DRAIN_CYCLES        = 40;
    localparam int              FILL_ITEMS          = 13;
    localparam logic [2:0]      FIRST_UNUSED_ACTION = 3'd5;
    localparam logic [2:0]      LAST_UNUSED_ACTION  = 3'd7;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_item_t rsp;

    int        error_count;
    int        outstanding;
    int        idle_cycles;
    bit        burst;
    bit        long_hold;

    fixed_capacity_multiset_table_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    fcmt_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one request and returns at the edge where it is accepted. Valid is
    // lowered only when a gap follows, so back-to-back transactions keep it high.
    task automatic send_item(input logic [2:0] act, input logic [ITEM_WIDTH-1:0] val);
        int gap;
        gap = burst ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid       <= 1'b1;
        req.action      <= act;
        req.item_value  <= val;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // Result side: a random stall before each transaction, or a long one on request.
    initial
    begin
        int gap;
        rsp_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                long_hold = 1'b0;
                gap = LONG_HOLD;
            end
            else
            begin
                gap = burst ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("fixed_capacity_multiset_table_top: mismatch");
        $finish;
    end

    initial
    begin
        logic [ITEM_WIDTH-1:0] pool [POOL_SIZE];
        logic [ITEM_WIDTH-1:0] val;
        logic [2:0]            act;
        int                    r;
        bit                    drain;

        burst          = 1'b0;
        long_hold      = 1'b0;
        rst_n          <= 1'b0;
        req_valid      <= 1'b0;
        req.action     <= ACT_QUERY;
        req.item_value <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty table, duplicates, extremes, unused codes, a full table.
        send_item(ACT_QUERY, '0);
        send_item(ACT_REMOVE, 32'h0000_0005);
        send_item(ACT_ADD, '0);
        send_item(ACT_ADD, '1);
        send_item(ACT_ADD_UNIQUE, '1);
        send_item(ACT_ADD_UNIQUE, 32'h0000_1234);
        send_item(ACT_ADD, '0);
        send_item(ACT_QUERY, '0);
        send_item(ACT_REMOVE, '0);
        send_item(FIRST_UNUSED_ACTION, '0);
        send_item(LAST_UNUSED_ACTION, '1);
        for (int k = 0; k < FILL_ITEMS; k++)
        begin
            send_item(ACT_ADD, 32'hC3C3_0000 + k);
        end
        send_item(ACT_ADD, '1);
        send_item(ACT_ADD_UNIQUE, 32'h0BAD_F00D);
        send_item(ACT_REMOVE, 32'hC3C3_0000);
        send_item(ACT_CLEAR, '1);
        send_item(ACT_QUERY, '1);

        // Random rounds over a small pool of values so that duplicates, full tables
        // and successful removals are common; rounds alternate filling and draining.
        for (int round = 0; round < ROUNDS; round++)
        begin
            for (int k = 0; k < POOL_SIZE; k++)
            begin
                r = $urandom_range(0, 5);
                pool[k] = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
            end
            drain = round[0];
            burst = ($urandom_range(0, 3) == 0);
            if (round == 3 || round == 9)
            begin
                burst     = 1'b1;
                long_hold = 1'b1;
            end
            for (int n = 0; n < ROUND_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r == 96)
                begin
                    act = ACT_CLEAR;
                end
                else if (r == 97)
                begin
                    act = FIRST_UNUSED_ACTION + 3'($urandom_range(0, 2));
                end
                else if (!drain)
                begin
                    act = (r < 50) ? ACT_ADD : (r < 65) ? ACT_ADD_UNIQUE :
                          (r < 80) ? ACT_REMOVE : ACT_QUERY;
                end
                else
                begin
                    act = (r < 20) ? ACT_ADD : (r < 30) ? ACT_ADD_UNIQUE :
                          (r < 75) ? ACT_REMOVE : ACT_QUERY;
                end
                val = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                                   : $urandom;
                send_item(act, val);
            end
        end
        req_valid <= 1'b0;
        burst = 1'b0;

        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("fixed_capacity_multiset_table_top: match");
        end
        else
        begin
            $display("fixed_capacity_multiset_table_top: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/fcmt_pkg.sv
design/fcmt_store.sv
design/fcmt_scan.sv
design/fcmt_seq.sv
design/fixed_capacity_multiset_table_top.sv
dv/fcmt_result_checker.sv
dv/tb_fixed_capacity_multiset_table_top.sv
